// File: design/bitmap_next_bit_search_defines.svh
// assertion macros of the bitmap search rtl, used by the controller
`ifndef BITMAP_NEXT_BIT_SEARCH_DEFINES_SVH
`define BITMAP_NEXT_BIT_SEARCH_DEFINES_SVH

// property checked at every clock edge outside reset
`define BNBS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent required in the cycle after the antecedent
`define BNBS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/bnbs_pkg.sv
// shared types, constants and helpers of the bitmap search block
package bnbs_pkg;

  localparam int IDX_W         = 13;
  localparam int WIDX_W        = 6;
  localparam int DATA_W        = 64;
  localparam int POS_W         = 6;
  localparam int MODE_W        = 2;
  localparam int DEF_WORD_BITS = 64;
  localparam int DEF_WORDS     = 64;

  localparam logic [MODE_W-1:0] MODE_WRITE      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIND_SET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_CORR,
    S_ISSUE,
    S_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic decode;
    logic corr;
    logic issue;
    logic scan;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic search;
    logic empty;
    logic scan_done;
  } dp_status_t;

  // index of the lowest set bit, halving search in POS_W steps
  function automatic logic [POS_W-1:0] first_set(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] x;
    logic [POS_W-1:0]  p;
    x = v;
    p = '0;
    for (int s = POS_W - 1; s >= 0; s--) begin
      if ((x & ((DATA_W'(1) << (1 << s)) - DATA_W'(1))) == '0) begin
        p[s] = 1'b1;
        x    = x >> (1 << s);
      end
    end
    return p;
  endfunction

endpackage

// File: design/bnbs_ram.sv
// generic single write port ram with registered read
module bnbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/bnbs_ctrl.sv
// controller state machine of the bitmap search block
`include "bitmap_next_bit_search_defines.svh"

module bnbs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  bnbs_pkg::dp_status_t   status,
  output bnbs_pkg::ctrl_cmd_t    cmd
);
  import bnbs_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (status.clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: state_nxt = status.search ? S_CORR : S_RESP;
      S_CORR:   state_nxt = status.empty ? S_RESP : S_ISSUE;
      S_ISSUE:  state_nxt = S_SCAN;
      S_SCAN:   if (status.scan_done) state_nxt = S_RESP;
      S_RESP:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_CLEAR:  cmd.clr = 1'b1;
      S_IDLE:   cmd.load = in_valid;
      S_DECODE: cmd.decode = 1'b1;
      S_CORR:   cmd.corr = 1'b1;
      S_ISSUE:  cmd.issue = 1'b1;
      S_SCAN:   cmd.scan = 1'b1;
      S_RESP:   cmd.out_load = out_free;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `BNBS_CHECK(a_no_overwrite, cmd.out_load |-> (!out_valid_r || out_ready), "pending word lost")
  `BNBS_CHECK(a_clear_blocks, (state_r == S_CLEAR) |-> !in_ready, "input taken while clearing")
  `BNBS_CHECK_NEXT(a_accept_decode, in_valid && in_ready, state_r == S_DECODE, "accept without decode")
  `BNBS_CHECK(a_rise_from_resp, $rose(out_valid_r) |-> $past(state_r == S_RESP), "stray result")

endmodule

// File: design/bnbs_dp.sv
// datapath of the bitmap search block: bitmap ram, word scan and result registers
module bnbs_dp #(
  parameter int WORD_BITS = bnbs_pkg::DEF_WORD_BITS,
  parameter int WORDS     = bnbs_pkg::DEF_WORDS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bnbs_pkg::ctrl_cmd_t                 cmd,
  output bnbs_pkg::dp_status_t                status,
  input  logic [bnbs_pkg::MODE_W-1:0]         in_mode,
  input  logic [bnbs_pkg::WIDX_W-1:0]         in_word_index,
  input  logic [bnbs_pkg::DATA_W-1:0]         in_word_data,
  input  logic [bnbs_pkg::IDX_W-1:0]          in_bit_limit,
  input  logic [bnbs_pkg::IDX_W-1:0]          in_start_bit,
  output logic [bnbs_pkg::IDX_W-1:0]          out_found_index,
  output logic                                out_found
);
  import bnbs_pkg::*;

  localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int OW      = $clog2(WORD_BITS);
  localparam int RSH     = 20;
  localparam int RECIP_W = 21;
  localparam int PROD_W  = IDX_W + RECIP_W;
  localparam int SUM_W   = IDX_W + 1;

  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((1 << RSH) / WORD_BITS);
  localparam logic [IDX_W-1:0]   WB_C     = IDX_W'(WORD_BITS);
  localparam logic [IDX_W-1:0]   WORDS_C  = IDX_W'(WORDS);
  localparam logic [AW-1:0]      LAST_C   = AW'(WORDS - 1);

  logic [MODE_W-1:0]    mode_r;
  logic [WIDX_W-1:0]    widx_r;
  logic [WORD_BITS-1:0] data_r;
  logic [IDX_W-1:0]     limit_r;
  logic [IDX_W-1:0]     start_r;
  logic [IDX_W-1:0]     q0_r;
  logic [IDX_W-1:0]     rd_word_r;
  logic [IDX_W-1:0]     base_r;
  logic [OW-1:0]        off_r;
  logic                 past_r;
  logic [IDX_W-1:0]     res_idx_r;
  logic                 res_found_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic                 out_found_r;
  logic [AW-1:0]        clr_cnt_r;

  logic                 search;
  logic                 want;
  logic                 wr_ok;
  logic [PROD_W-1:0]    prod;
  logic [IDX_W-1:0]     qwb;
  logic [IDX_W-1:0]     rem0;
  logic                 fix;
  logic [IDX_W-1:0]     rem;
  logic [IDX_W-1:0]     q;
  logic                 empty;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [WORD_BITS-1:0] word_v;
  logic [WORD_BITS-1:0] cand;
  logic [POS_W-1:0]     pos;
  logic [SUM_W-1:0]     idx_sum;
  logic [SUM_W-1:0]     end_sum;
  logic [SUM_W-1:0]     lim_ext;
  logic                 hit;
  logic                 scan_done;

  assign search = (mode_r == MODE_FIND_SET) || (mode_r == MODE_FIND_CLEAR);
  assign want   = (mode_r == MODE_FIND_SET);
  assign wr_ok  = (mode_r == MODE_WRITE) && (IDX_W'(widx_r) < WORDS_C);

  // start / WORD_BITS by reciprocal, low by at most one
  assign prod  = PROD_W'(start_r) * PROD_W'(RECIP);
  assign qwb   = q0_r * WB_C;
  assign rem0  = start_r - qwb;
  assign fix   = (rem0 >= WB_C);
  assign rem   = fix ? (rem0 - WB_C) : rem0;
  assign q     = q0_r + IDX_W'(fix);
  assign empty = (start_r >= limit_r);

  assign ram_we    = cmd.clr || (cmd.decode && wr_ok);
  assign ram_waddr = cmd.clr ? clr_cnt_r : AW'(widx_r);
  assign ram_wdata = cmd.clr ? '0 : data_r;
  assign ram_re    = cmd.issue || cmd.scan;

  bnbs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_word_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // words past the store read as zero
  assign word_v  = past_r ? '0 : ram_rdata;
  assign cand    = (want ? word_v : ~word_v) & ({WORD_BITS{1'b1}} << off_r);
  assign pos     = first_set(DATA_W'(cand));
  assign idx_sum = {1'b0, base_r} + SUM_W'(pos);
  assign end_sum = {1'b0, base_r} + SUM_W'(WB_C);
  assign lim_ext = {1'b0, limit_r};
  assign hit       = (|cand) && (idx_sum < lim_ext);
  // a set-bit search past the store can never match
  assign scan_done = hit || (end_sum >= lim_ext) || (past_r && want);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      widx_r  <= in_word_index;
      data_r  <= in_word_data[WORD_BITS-1:0];
      limit_r <= in_bit_limit;
      start_r <= in_start_bit;
    end
    if (cmd.decode) begin
      q0_r <= prod[RSH +: IDX_W];
      if (!search) begin
        res_idx_r   <= '0;
        res_found_r <= 1'b0;
      end
    end
    if (cmd.corr) begin
      rd_word_r <= q;
      base_r    <= start_r - rem;
      off_r     <= rem[OW-1:0];
      if (empty) begin
        res_idx_r   <= limit_r;
        res_found_r <= 1'b0;
      end
    end
    if (cmd.issue || cmd.scan) begin
      past_r    <= (rd_word_r >= WORDS_C);
      rd_word_r <= rd_word_r + IDX_W'(1);
    end
    if (cmd.scan) begin
      base_r <= end_sum[IDX_W-1:0];
      off_r  <= '0;
      if (scan_done) begin
        res_idx_r   <= hit ? idx_sum[IDX_W-1:0] : limit_r;
        res_found_r <= hit;
      end
    end
    if (cmd.out_load) begin
      out_idx_r   <= res_idx_r;
      out_found_r <= res_found_r;
    end
  end

  assign status.clr_last  = (clr_cnt_r == LAST_C);
  assign status.search    = search;
  assign status.empty     = empty;
  assign status.scan_done = scan_done;

  assign out_found_index = out_idx_r;
  assign out_found       = out_found_r;

endmodule

// File: design/bitmap_next_bit_search.sv
// top level of the bitmap next-bit search block
// Usage: each input word either writes one bitmap word (mode 0) or searches
// [in_start_bit, in_bit_limit) for the lowest set (mode 1) or clear (mode 2)
// bit; every input word yields exactly one output word. Both channels use
// valid/ready. out_found_index is the hit index, or the limit on a search
// miss; a write or unused mode 3 gives index 0, out_found low. A search
// reads bitmap words upward from the one holding in_start_bit, one ram read
// per cycle in the scan loop, until a hit, the limit or, in a set-bit search,
// the end of the store; this scan loop sets the search time. A new word is
// taken only after the previous result has entered the output register.
// After reset the ram is zeroed one word per cycle, all WORDS words, with
// in_ready low. The output register holds a result while out_ready is low;
// the next input word is still accepted and runs, and its result waits in
// the datapath until the output register is free.
module bitmap_next_bit_search #(
  parameter int WORD_BITS = bnbs_pkg::DEF_WORD_BITS,
  parameter int WORDS     = bnbs_pkg::DEF_WORDS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bnbs_pkg::MODE_W-1:0]  in_mode,
  input  logic [bnbs_pkg::WIDX_W-1:0]  in_word_index,
  input  logic [bnbs_pkg::DATA_W-1:0]  in_word_data,
  input  logic [bnbs_pkg::IDX_W-1:0]   in_bit_limit,
  input  logic [bnbs_pkg::IDX_W-1:0]   in_start_bit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bnbs_pkg::IDX_W-1:0]   out_found_index,
  output logic                         out_found
);
  import bnbs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bnbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bnbs_dp #(
    .WORD_BITS (WORD_BITS),
    .WORDS     (WORDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_mode         (in_mode),
    .in_word_index   (in_word_index),
    .in_word_data    (in_word_data),
    .in_bit_limit    (in_bit_limit),
    .in_start_bit    (in_start_bit),
    .out_found_index (out_found_index),
    .out_found       (out_found)
  );

endmodule
